/* design/assert_macros.svh */
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// concurrent assertion on the block clock and reset
`define ASSERT_CLKD(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_CLKD(lbl, prop, msg)
`endif

`endif

/* design/gnls_pkg.sv */
// package for the gated nearest landmark search: sizes, types and states
package gnls_pkg;

  localparam int unsigned LM_DEPTH  = 256;
  localparam int unsigned LM_IDX_W  = $clog2(LM_DEPTH);
  localparam int unsigned SCAN_W    = LM_IDX_W + 1;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned SQ_W      = 2 * COORD_W + 1;
  localparam int unsigned DIST_W    = 50;
  localparam int unsigned GATE_W    = 23;
  localparam int unsigned MIDX_W    = 8;
  localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(1024);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // one table entry handed to the distance unit
  typedef struct packed {
    logic                      valid;
    logic [LM_IDX_W-1:0]       idx;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
  } dist_req_t;

  // squared distance coming out of the distance unit
  typedef struct packed {
    logic                valid;
    logic [LM_IDX_W-1:0] idx;
    logic [DIST_W-1:0]   dsq;
  } dist_res_t;

endpackage

/* design/gnls_ifs.sv */
// channel interfaces: query/write input, result output, gate config write
interface gnls_in_if;
  import gnls_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [7:0]                entry_index;
  logic                      entry_valid;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  modport source (output valid, operation, entry_index, entry_valid, point_x, point_y,
                  input ready);
  modport sink (input valid, operation, entry_index, entry_valid, point_x, point_y,
                output ready);
endinterface

interface gnls_res_if;
  import gnls_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [MIDX_W-1:0] match_index;
  logic [DIST_W-1:0] match_dist_sq;
  modport source (output valid, found, match_index, match_dist_sq, input ready);
  modport sink (input valid, found, match_index, match_dist_sq, output ready);
endinterface

interface gnls_cfg_if;
  import gnls_pkg::*;
  logic              valid;
  logic              ready;
  logic [GATE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* design/gated_nearest_landmark_search.sv */
// Gated nearest landmark search: a write returns its result word the cycle after accept.
// A query scans all 256 entries through the single store read port, then passes the
// 3-stage distance pipeline, the running-best update and the result register.
// One item is in work at a time: the next word waits for idle and a free result register.
// Reset clears the control state and all valid marks at once and sets the gate
// to 1.0 m; the coordinate store needs no clearing pass.
`include "assert_macros.svh"

module gated_nearest_landmark_search (
  input  logic              clk_i,
  input  logic              rst_ni,
  gnls_in_if.sink           in_i,
  gnls_res_if.source        res_o,
  gnls_cfg_if.sink          cfg_i
);
  import gnls_pkg::*;

  state_e state_q, state_d;

  logic [GATE_W-1:0]         gate_q;
  logic [LM_DEPTH-1:0]       valid_q;
  logic [2*COORD_W-1:0]      mem [LM_DEPTH];
  logic [2*COORD_W-1:0]      rd_q;
  logic                      rd_v_q;
  logic [LM_IDX_W-1:0]       rd_idx_q;
  logic [SCAN_W-1:0]         scan_addr_q;
  logic signed [COORD_W-1:0] qx_q, qy_q;
  logic [DIST_W-1:0]         best_q, gate_sq_q, gate_sq;
  logic [LM_IDX_W-1:0]       best_idx_q;
  logic                      hit_q;

  logic                      res_valid_q;
  logic                      res_found_q;
  logic [MIDX_W-1:0]         res_idx_q;
  logic [DIST_W-1:0]         res_dist_q;

  logic      out_free, in_acc, acc_write, acc_query;
  logic      in_ready, scan_issue, scan_done, load_result;
  logic      unit_busy;
  dist_req_t req;
  dist_res_t dres;

  assign out_free  = !res_valid_q || res_o.ready;
  assign in_acc    = in_i.valid && in_ready;
  assign acc_write = in_acc && (op_e'(in_i.operation) == OP_WRITE);
  assign acc_query = in_acc && (op_e'(in_i.operation) == OP_QUERY);
  assign scan_done = scan_addr_q[SCAN_W-1] && !rd_v_q && !unit_busy && !dres.valid;
  assign gate_sq   = DIST_W'(gate_q) * DIST_W'(gate_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc_query) state_d = ST_SCAN;
      ST_SCAN: if (load_result) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready    = 1'b0;
    scan_issue  = 1'b0;
    load_result = 1'b0;
    case (state_q)
      ST_IDLE: in_ready = out_free;
      ST_SCAN: begin
        scan_issue  = !scan_addr_q[SCAN_W-1];
        load_result = scan_done && out_free;
      end
      default: ;
    endcase
  end

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // gate register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gate_q <= GATE_RESET;
    else if (cfg_i.valid) gate_q <= cfg_i.data;
  end

  // valid marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= '0;
    else if (acc_write) valid_q[in_i.entry_index[LM_IDX_W-1:0]] <= in_i.entry_valid;
  end

  // coordinate store, one write and one read port
  always_ff @(posedge clk_i) begin
    if (acc_write) mem[in_i.entry_index[LM_IDX_W-1:0]] <= {in_i.point_x, in_i.point_y};
    rd_q     <= mem[scan_addr_q[LM_IDX_W-1:0]];
    rd_idx_q <= scan_addr_q[LM_IDX_W-1:0];
  end

  // read flag: only valid entries go to the distance unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_v_q <= 1'b0;
    else         rd_v_q <= scan_issue && valid_q[scan_addr_q[LM_IDX_W-1:0]];
  end

  // scan address and query point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scan_addr_q <= '0;
    else if (acc_query) scan_addr_q <= '0;
    else if (scan_issue) scan_addr_q <= scan_addr_q + SCAN_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (acc_query) begin
      qx_q      <= in_i.point_x;
      qy_q      <= in_i.point_y;
      gate_sq_q <= gate_sq;
    end
  end

  assign req.valid = rd_v_q;
  assign req.idx   = rd_idx_q;
  assign req.lx    = rd_q[2*COORD_W-1:COORD_W];
  assign req.ly    = rd_q[COORD_W-1:0];
  assign req.qx    = qx_q;
  assign req.qy    = qy_q;

  gnls_dist_unit u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (dres),
    .busy_o (unit_busy)
  );

  // running best: starts at the squared gate, so one compare covers both tests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hit_q <= 1'b0;
    else if (acc_query) hit_q <= 1'b0;
    else if (dres.valid && (dres.dsq < best_q)) hit_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (acc_query) begin
      best_q     <= gate_sq;
      best_idx_q <= '0;
    end else if (dres.valid && (dres.dsq < best_q)) begin
      best_q     <= dres.dsq;
      best_idx_q <= dres.idx;
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else if (acc_write || load_result) res_valid_q <= 1'b1;
    else if (res_o.ready) res_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (acc_write) begin
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
      res_dist_q  <= '0;
    end else if (load_result) begin
      res_found_q <= hit_q;
      res_idx_q   <= hit_q ? MIDX_W'(best_idx_q) : '0;
      res_dist_q  <= hit_q ? best_q : '0;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.found         = res_found_q;
  assign res_o.match_index   = res_idx_q;
  assign res_o.match_dist_sq = res_dist_q;

  // checks
  `ASSERT_CLKD(a_ready_idle, in_i.ready |-> (state_q == ST_IDLE), "input ready outside idle")
  `ASSERT_CLKD(a_no_overwrite, load_result |-> (!res_valid_q || res_o.ready), "result overwritten")
  `ASSERT_CLKD(a_best_gated, hit_q |-> (best_q < gate_sq_q), "best match outside gate")
  `ASSERT_CLKD(a_scan_bound, (state_q == ST_SCAN) |-> (scan_addr_q <= SCAN_W'(LM_DEPTH)), "scan address overrun")

endmodule

/* design/gnls_dist_unit.sv */
// pipelined squared-distance unit shared by every entry of a scan
module gnls_dist_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gnls_pkg::dist_req_t req_i,
  output gnls_pkg::dist_res_t res_o,
  output logic               busy_o
);
  import gnls_pkg::*;

  logic                     v1_q, v2_q, v3_q;
  logic [LM_IDX_W-1:0]      idx1_q, idx2_q, idx3_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic [DIST_W-1:0]        dist_q;
  logic signed [PROD_W-1:0] prod_x, prod_y;

  // squares of the registered differences, always non-negative
  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // differences, squares, sum
  always_ff @(posedge clk_i) begin
    dx_q   <= DIFF_W'(req_i.qx) - DIFF_W'(req_i.lx);
    dy_q   <= DIFF_W'(req_i.qy) - DIFF_W'(req_i.ly);
    idx1_q <= req_i.idx;
    sqx_q  <= prod_x[SQ_W-1:0];
    sqy_q  <= prod_y[SQ_W-1:0];
    idx2_q <= idx1_q;
    dist_q <= DIST_W'(sqx_q) + DIST_W'(sqy_q);
    idx3_q <= idx2_q;
  end

  assign res_o.valid = v3_q;
  assign res_o.idx   = idx3_q;
  assign res_o.dsq   = dist_q;
  assign busy_o      = v1_q | v2_q | v3_q;

endmodule

/* tb/tb_gated_nearest_landmark_search.sv */
// testbench for the gated nearest landmark search: random table writes and queries, self-checked
module tb_gated_nearest_landmark_search;
  timeunit 1ns;
  timeprecision 1ps;

  import gnls_pkg::*;

  localparam longint COORD_MAX  = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN  = -COORD_MAX - 1;
  localparam longint GATE_MAX   = (longint'(1) << GATE_W) - 1;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_ITEMS = 170;
  localparam int     DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 3_000_000;

  // one word on the input channel
  typedef struct {
    op_e                       op;
    logic [7:0]                idx;
    logic                      on;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } lm_item_t;

  // one word on the result channel
  typedef struct packed {
    logic              found;
    logic [MIDX_W-1:0] index;
    logic [DIST_W-1:0] dist_sq;
  } match_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gnls_in_if  in_ch ();
  gnls_res_if res_ch ();
  gnls_cfg_if cfg_ch ();

  gated_nearest_landmark_search DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always #4 clk_i = ~clk_i;

  // words waiting to be sent, and matches waiting to come back
  lm_item_t item_queue[$];
  match_t   expected_matches[$];

  // flow-control knobs, percent of cycles
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;

  // shadow of the table as the stimulus leaves it, used only to aim queries and tie writes
  logic signed [COORD_W-1:0] aim_x [LM_DEPTH];
  logic signed [COORD_W-1:0] aim_y [LM_DEPTH];
  bit                        aim_on[LM_DEPTH];

  // predictor state
  logic signed [COORD_W-1:0] lm_x [LM_DEPTH];
  logic signed [COORD_W-1:0] lm_y [LM_DEPTH];
  bit                        lm_on[LM_DEPTH];
  logic [GATE_W-1:0]         gate_setting;

  int unsigned mismatches = 0;
  int unsigned n_writes   = 0;
  int unsigned n_queries  = 0;
  int unsigned n_hits     = 0;
  int unsigned gate_writes = 0;
  longint      cycle_count = 0;

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  // nearest valid landmark strictly inside the gate, lowest index on ties
  function automatic match_t nearest_in_gate(logic signed [COORD_W-1:0] qx,
                                             logic signed [COORD_W-1:0] qy);
    match_t          m;
    longint          dx;
    longint          dy;
    longint unsigned d;
    longint unsigned best;
    longint unsigned gate_sq;
    m = '0;
    best = 0;
    gate_sq = longint'(gate_setting) * longint'(gate_setting);
    for (int i = 0; i < LM_DEPTH; i++) begin
      if (lm_on[i]) begin
        dx = longint'(qx) - longint'(lm_x[i]);
        dy = longint'(qy) - longint'(lm_y[i]);
        d = dx * dx + dy * dy;
        if (d < gate_sq && (!m.found || d < best)) begin
          m.found = 1'b1;
          m.index = MIDX_W'(i);
          best = d;
        end
      end
    end
    if (m.found) m.dist_sq = DIST_W'(best);
    return m;
  endfunction

  // driver: next pending word, with random gaps
  always @(posedge clk_i) begin
    lm_item_t it;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (item_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        it = item_queue.pop_front();
        in_ch.operation   <= it.op;
        in_ch.entry_index <= it.idx;
        in_ch.entry_valid <= it.on;
        in_ch.point_x     <= it.x;
        in_ch.point_y     <= it.y;
        in_ch.valid       <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor: track gate and table, predict on accept, compare on result
  always @(posedge clk_i) begin
    match_t want;
    match_t got;
    cycle_count++;
    if (!rst_ni) begin
      gate_setting = GATE_RESET;
      for (int i = 0; i < LM_DEPTH; i++) begin
        lm_x[i] = '0;
        lm_y[i] = '0;
        lm_on[i] = 1'b0;
      end
    end else begin
      // gate update
      if (cfg_ch.valid && cfg_ch.ready) gate_setting = cfg_ch.data;
      // accepted word
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_WRITE) begin
          lm_x[in_ch.entry_index] = in_ch.point_x;
          lm_y[in_ch.entry_index] = in_ch.point_y;
          lm_on[in_ch.entry_index] = in_ch.entry_valid;
          want = '0;
          expected_matches.insert(expected_matches.size(), want);
          n_writes++;
        end else begin
          want = nearest_in_gate(in_ch.point_x, in_ch.point_y);
          expected_matches.insert(expected_matches.size(), want);
          n_queries++;
          if (want.found) n_hits++;
        end
      end
      // result word
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.found, res_ch.match_index, res_ch.match_dist_sq};
        if (expected_matches.size() == 0) begin
          flag_mismatch("result with nothing outstanding", got.found, 0);
        end else begin
          want = expected_matches.pop_front();
          if (got.found !== want.found) flag_mismatch("found", got.found, want.found);
          if (got.index !== want.index) flag_mismatch("match_index", got.index, want.index);
          if (got.dist_sq !== want.dist_sq)
            flag_mismatch("match_dist_sq", got.dist_sq, want.dist_sq);
        end
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    if (v < COORD_MIN) return COORD_W'(COORD_MIN);
    return COORD_W'(v);
  endfunction

  function automatic longint spread(longint m);
    return longint'($urandom_range(0, 2 * m)) - m;
  endfunction

  task automatic put_write(logic [7:0] idx, logic on, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y);
    lm_item_t it;
    it = '{OP_WRITE, idx, on, x, y};
    item_queue.insert(item_queue.size(), it);
    aim_x[idx] = x;
    aim_y[idx] = y;
    aim_on[idx] = on;
  endtask

  task automatic put_query(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    lm_item_t it;
    it = '{OP_QUERY, 8'($urandom()), 1'($urandom()), x, y};
    item_queue.insert(item_queue.size(), it);
  endtask

  // an entry that the stimulus has left valid if 16 tries find one, mostly among the low ones
  function automatic logic [7:0] pick_live();
    logic [7:0] k;
    k = 8'($urandom_range(31));
    for (int t = 0; t < 16; t++) begin
      k = ($urandom_range(99) < 60) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
      if (aim_on[k]) break;
    end
    return k;
  endfunction

  // clustered landmarks and queries aimed near them, plus some noise
  task automatic put_random(longint g, longint cx, longint cy);
    longint      s;
    int unsigned j;
    logic [7:0]  k;
    logic [7:0]  m;
    s = (g == 0) ? 4096 : ((g > 1048576) ? 1048576 : g);
    j = $urandom_range(99);
    if ($urandom_range(99) < 45) begin
      k = ($urandom_range(99) < 60) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
      if (j < 10) begin
        put_write(k, 1'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()));
      end else if (j < 22) begin
        // same point at a second index makes a tie
        m = pick_live();
        put_write(k, 1'b1, aim_x[m], aim_y[m]);
      end else begin
        put_write(k, ($urandom_range(99) < 85), clamp_coord(cx + spread(4 * s)),
                  clamp_coord(cy + spread(4 * s)));
      end
    end else begin
      k = pick_live();
      if (j < 10) begin
        put_query(COORD_W'($urandom()), COORD_W'($urandom()));
      end else if (j < 16) begin
        // exactly on the gate circle of one landmark
        put_query(clamp_coord(longint'(aim_x[k]) + g), aim_y[k]);
      end else if (j < 24) begin
        put_query(aim_x[k], aim_y[k]);
      end else begin
        put_query(clamp_coord(longint'(aim_x[k]) + spread(s)),
                  clamp_coord(longint'(aim_y[k]) + spread(s)));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (item_queue.size() != 0 || in_ch.valid || expected_matches.size() != 0);
  endtask

  task automatic write_gate(logic [GATE_W-1:0] g);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= g;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    gate_writes++;
  endtask

  // run watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_gated_nearest_landmark_search NOT OK");
    $finish;
  end

  // stimulus and end of run
  initial begin
    longint      gate_plan[RAND_PHASES];
    int unsigned gap_plan[4];
    int unsigned stall_plan[4];
    longint      cx;
    longint      cy;
    gate_plan  = '{2048, 0, GATE_MAX, 1, 40000, 0, 700, 1024};
    gap_plan   = '{0, 50, 0, 15};
    stall_plan = '{0, 0, 50, 15};
    gate_plan[5] = $urandom_range(32'(GATE_MAX));
    for (int i = 0; i < LM_DEPTH; i++) begin
      aim_x[i] = '0;
      aim_y[i] = '0;
      aim_on[i] = 1'b0;
    end
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, gate at its reset value of one metre
    put_query(COORD_W'(0), COORD_W'(0));                       // empty table
    put_write(8'd0, 1'b1, COORD_W'(0), COORD_W'(0));
    put_query(COORD_W'(0), COORD_W'(0));                       // zero distance
    put_query(COORD_W'(1024), COORD_W'(0));                    // on the gate, no match
    put_query(COORD_W'(1023), COORD_W'(0));                    // just inside
    put_write(8'd255, 1'b1, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
    put_write(8'd254, 1'b1, COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
    put_query(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX - 7));
    put_query(COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
    put_write(8'd0, 1'b0, COORD_W'(0), COORD_W'(0));           // removed entry
    put_write(8'd7, 1'b1, COORD_W'(100), COORD_W'(0));
    put_write(8'd3, 1'b1, COORD_W'(-100), COORD_W'(0));
    put_query(COORD_W'(0), COORD_W'(0));                       // tie goes to the lower index
    put_query(COORD_W'(COORD_MAX), COORD_W'(COORD_MIN));
    put_query(COORD_W'(100), COORD_W'(0));
    wait_idle();

    // gate of zero matches nothing
    write_gate(GATE_W'(0));
    put_query(COORD_W'(100), COORD_W'(0));
    put_query(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
    wait_idle();

    // widest gate
    write_gate(GATE_W'(GATE_MAX));
    put_query(COORD_W'(0), COORD_W'(0));
    put_query(COORD_W'(COORD_MAX), COORD_W'(COORD_MIN));
    put_query(COORD_W'(4000000), COORD_W'(4000000));
    put_query(COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
    wait_idle();

    // random phases across gate settings and flow-control modes
    for (int p = 0; p < RAND_PHASES; p++) begin
      send_gap_pct = gap_plan[p / 2];
      stall_pct = stall_plan[p / 2];
      write_gate(GATE_W'(gate_plan[p]));
      cx = spread(longint'(1) << 22);
      cy = spread(longint'(1) << 22);
      for (int n = 0; n < PHASE_ITEMS; n++) put_random(gate_plan[p], cx, cy);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_matches.size() != 0)
      flag_mismatch("results never returned", 0, expected_matches.size());
    $display("covered %0d table writes and %0d queries, %0d of them inside the gate,",
             n_writes, n_queries, n_hits);
    $display("over %0d gate writes and four flow-control modes; %0d mismatches",
             gate_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb_gated_nearest_landmark_search OK");
    end else begin
      $display("tb_gated_nearest_landmark_search NOT OK");
    end
    $finish;
  end

endmodule
